@@ design/scalar_vector_execute_unit_defines.svh @@
// assertion macros for the execute unit checker
`ifndef SCALAR_VECTOR_EXECUTE_UNIT_DEFINES_SVH
`define SCALAR_VECTOR_EXECUTE_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SVEU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// implication checked in the cycle after the antecedent
`define SVEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ design/sveu_pkg.sv @@
// shared constants, types and helpers of the execute unit
package sveu_pkg;
  localparam int Cores = 4;
  localparam int Lanes = 8;
  localparam int CoreW = 2;
  localparam int LaneW = (Lanes > 1) ? $clog2(Lanes) : 1;
  localparam int SRegs = 256;
  localparam int VRegs = 32;
  localparam int VRegW = 5;
  // both register memories hold 1024 words: {core, reg} and {core, reg, lane}
  localparam int SMemDepth = Cores * SRegs;
  localparam int VMemDepth = Cores * VRegs * Lanes;
  localparam int MemAw = 10;

  localparam logic [7:0] OP_HALT = 8'h00;
  localparam logic [7:0] OP_ADD = 8'h01;
  localparam logic [7:0] OP_SUB = 8'h02;
  localparam logic [7:0] OP_MUL = 8'h03;
  localparam logic [7:0] OP_DIV = 8'h04;
  localparam logic [7:0] OP_MOV = 8'h07;
  localparam logic [7:0] OP_ADDI = 8'h09;
  localparam logic [7:0] OP_SUBI = 8'h0A;
  localparam logic [7:0] OP_MULI = 8'h0B;
  localparam logic [7:0] OP_DIVI = 8'h0C;
  localparam logic [7:0] OP_LDI = 8'h0F;
  localparam logic [7:0] OP_BR_LO = 8'h10;
  localparam logic [7:0] OP_BR_HI = 8'h1E;
  localparam logic [7:0] OP_VADD = 8'h21;
  localparam logic [7:0] OP_VSUB = 8'h22;
  localparam logic [7:0] OP_VMUL = 8'h23;
  localparam logic [7:0] OP_VADDS = 8'h29;
  localparam logic [7:0] OP_VSUBS = 8'h2A;
  localparam logic [7:0] OP_VMULS = 8'h2B;
  localparam logic [3:0] COND_ALWAYS = 4'hE;

  typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL} alu_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_VRD, ST_VLANE, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [31:0] quotient;
  } div_rsp_t;

  // flags packed as {v, c, n, z}
  function automatic logic cond_holds(input logic [3:0] f, input logic [3:0] code);
    logic z, n, c, v, r;
    z = f[0]; n = f[1]; c = f[2]; v = f[3];
    case (code)
      4'h0: r = z;
      4'h1: r = !z;
      4'h2: r = c;
      4'h3: r = !c;
      4'h4: r = n;
      4'h5: r = !n;
      4'h6: r = v;
      4'h7: r = !v;
      4'h8: r = c && !z;
      4'h9: r = !c || z;
      4'hA: r = n == v;
      4'hB: r = n != v;
      4'hC: r = !z && (n == v);
      4'hD: r = z || (n != v);
      COND_ALWAYS: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction
endpackage

@@ design/sveu_alu.sv @@
// shared add, subtract and multiply unit with flag generation
module sveu_alu (
  input  sveu_pkg::alu_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic [31:0]       r,
  output logic [3:0]        flags
);
  import sveu_pkg::*;
  logic [32:0] sum;
  logic [31:0] dif;
  logic [31:0] prod;

  // one result selected per cycle
  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    dif = a - b;
    prod = a * b;
    flags = '0;
    case (op)
      ALU_ADD: begin
        r = sum[31:0];
        flags[2] = sum[32];
        flags[3] = (a[31] == b[31]) && (r[31] != a[31]);
      end
      ALU_SUB: begin
        r = dif;
        flags[2] = a >= b;
        flags[3] = (a[31] != b[31]) && (r[31] == b[31]);
      end
      ALU_MUL: r = prod;
      default: r = '0;
    endcase
    flags[0] = r == '0;
    flags[1] = r[31];
  end
endmodule

@@ design/sveu_div.sv @@
// radix-2 signed divider, one quotient bit per cycle
module sveu_div (
  input  logic               clk,
  input  logic               rst,
  input  sveu_pkg::div_req_t req,
  output sveu_pkg::div_rsp_t rsp
);
  import sveu_pkg::*;
  logic [31:0] rem, quo, dvs;
  logic [5:0] cnt;
  logic neg, busy, done;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [31:0] ua, ub;

  always_comb begin
    ua = req.dividend[31] ? (~req.dividend + 32'd1) : req.dividend;
    ub = req.divisor[31] ? (~req.divisor + 32'd1) : req.divisor;
    rem_sh = {rem[30:0], quo[31]};
    trial = {1'b0, rem_sh} - {1'b0, dvs};
  end

  // shift-subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
        rem <= '0;
        quo <= ua;
        dvs <= ub;
        neg <= req.dividend[31] ^ req.divisor[31];
      end else if (busy) begin
        if (trial[32]) begin
          rem <= rem_sh;
          quo <= {quo[30:0], 1'b0};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = neg ? (~quo + 32'd1) : quo;
endmodule

@@ design/scalar_vector_execute_unit.sv @@
// Execute unit for four cores' instructions. After reset a clearing pass
// zeroes the scalar and vector register memories (one word of each per
// cycle) before the first request is taken. A request then passes accept,
// register read, execute and result for scalar, branch, halt and ignored
// work; vector work adds a read and an ALU step for every lane, since each
// lane is read in one state and run through the single shared ALU in the
// next, and divides wait on the one-bit-per-cycle divider in between.
// One request at a time: in_stall stays high from acceptance until the
// result has been taken, so a stalled result holds off the next request.
module scalar_vector_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  core_id,
  input  logic [7:0]  opcode,
  input  logic [7:0]  dest_index,
  input  logic [7:0]  src_a_index,
  input  logic [7:0]  src_b_field,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  core_out,
  output logic [31:0] next_pc,
  output logic        flag_zero,
  output logic        flag_negative,
  output logic        flag_carry,
  output logic        flag_overflow,
  output logic        branch_taken,
  output logic        halted,
  output logic signed [31:0] scalar_written
);
  import sveu_pkg::*;

  // memories: scalar by {core, reg}, vector by {core, reg, lane}
  logic [31:0] smem [SMemDepth];
  logic [31:0] vmem [VMemDepth];
  logic [31:0] pc_r [Cores];
  logic [3:0]  fl_r [Cores];
  logic [Cores-1:0] hlt;

  state_t state, state_next;
  logic [MemAw-1:0] clr;
  logic [CoreW-1:0] c;
  logic [7:0] op, d, sa, sb;
  logic [31:0] ra, rb;
  logic [LaneW-1:0] lane;
  logic [31:0] vx, vy, sop;

  // shared alu
  alu_op_t aop;
  logic [31:0] aa, ab, ar;
  logic [3:0] af;
  sveu_alu u_alu (.op(aop), .a(aa), .b(ab), .r(ar), .flags(af));

  div_req_t dreq;
  div_rsp_t drsp;
  sveu_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // request decode and scalar results
  logic active, is_vec, is_vs, is_br, is_div_op, is_sw, sets_fl, taken;
  logic [31:0] pc_cur, pc_new, wres;
  logic [3:0] fl_new;
  always_comb begin
    active = !hlt[c];
    is_vs = (op == OP_VADDS) || (op == OP_VSUBS) || (op == OP_VMULS);
    is_vec = is_vs || (op == OP_VADD) || (op == OP_VSUB) || (op == OP_VMUL);
    is_br = (op >= OP_BR_LO) && (op <= OP_BR_HI);
    is_div_op = (op == OP_DIV && rb != '0) || (op == OP_DIVI && sa != '0 && sb != '0);
    is_sw = (op == OP_ADD) || (op == OP_ADDI) || (op == OP_SUB) || (op == OP_SUBI) ||
            (op == OP_MUL) || (op == OP_MULI) || (op == OP_MOV) || (op == OP_LDI);
    sets_fl = (op == OP_ADD) || (op == OP_ADDI) || (op == OP_SUB) || (op == OP_SUBI);
    taken = is_br && cond_holds(fl_r[c], op[3:0]);
    pc_cur = pc_r[c];
    if (taken) pc_new = pc_cur + {{22{sb[7]}}, sb, 2'b00};
    else pc_new = pc_cur + 32'd4;
    fl_new = sets_fl ? af : fl_r[c];
    case (op)
      OP_MOV: wres = rb;
      OP_LDI: wres = {24'd0, sb};
      default: wres = ar;
    endcase
  end

  // alu operand select and divider request
  always_comb begin
    sop = (sb < 8'd32 && rb != '0) ? rb : {24'd0, sb};
    aop = ALU_ADD;
    aa = ra;
    ab = rb;
    case (op)
      OP_ADD: aop = ALU_ADD;
      OP_ADDI: begin aop = ALU_ADD; ab = {24'd0, sb}; end
      OP_SUB: aop = ALU_SUB;
      OP_SUBI: begin aop = ALU_SUB; ab = {24'd0, sb}; end
      OP_MUL: aop = ALU_MUL;
      OP_MULI: begin aop = ALU_MUL; ab = {24'd0, sb}; end
      OP_VADD: begin aop = ALU_ADD; aa = vx; ab = vy; end
      OP_VSUB: begin aop = ALU_SUB; aa = vx; ab = vy; end
      OP_VMUL: begin aop = ALU_MUL; aa = vx; ab = vy; end
      OP_VADDS: begin aop = ALU_ADD; aa = vx; ab = sop; end
      OP_VSUBS: begin aop = ALU_SUB; aa = vx; ab = sop; end
      OP_VMULS: begin aop = ALU_MUL; aa = vx; ab = sop; end
      default: aop = ALU_ADD;
    endcase
    dreq.start = (state == ST_EXEC) && active && is_div_op;
    dreq.dividend = ra;
    dreq.divisor = (op == OP_DIV) ? rb : {24'd0, sb};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr == '1) state_next = ST_IDLE;
      ST_IDLE: if (in_valid) state_next = ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: begin
        if (!active) state_next = ST_DONE;
        else if (is_div_op) state_next = ST_DIV;
        else if (is_vec) state_next = ST_VRD;
        else state_next = ST_DONE;
      end
      ST_DIV: if (drsp.done) state_next = ST_DONE;
      ST_VRD: state_next = ST_VLANE;
      ST_VLANE: state_next = (lane == LaneW'(Lanes - 1)) ? ST_DONE : ST_VRD;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = state != ST_IDLE;
  end

  // memory write ports
  logic s_we, v_we;
  logic [MemAw-1:0] s_waddr, v_waddr;
  logic [31:0] s_wdata, v_wdata;
  always_comb begin
    s_we = 1'b0;
    s_waddr = clr;
    s_wdata = '0;
    v_we = 1'b0;
    v_waddr = clr;
    v_wdata = '0;
    case (state)
      ST_CLEAR: begin
        s_we = 1'b1;
        v_we = 1'b1;
      end
      ST_EXEC: begin
        s_we = active && is_sw;
        s_waddr = {c, d};
        s_wdata = wres;
      end
      ST_DIV: begin
        s_we = drsp.done;
        s_waddr = {c, d};
        s_wdata = drsp.quotient;
      end
      ST_VLANE: begin
        v_we = 1'b1;
        v_waddr = {c, d[VRegW-1:0], lane};
        v_wdata = ar;
      end
      default: ;
    endcase
  end

  // scalar memory, two registered reads
  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= s_wdata;
    ra <= smem[{c, sa}];
    rb <= smem[{c, sb}];
  end

  // vector memory, two registered reads of the current lane
  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    vx <= vmem[{c, sa[VRegW-1:0], lane}];
    vy <= vmem[{c, sb[VRegW-1:0], lane}];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
      lane <= '0;
      out_valid <= 1'b0;
      hlt <= '0;
      for (int i = 0; i < Cores; i++) begin
        pc_r[i] <= '0;
        fl_r[i] <= '0;
      end
    end else begin
      state <= state_next;
      out_valid <= (state_next == ST_DONE);
      case (state)
        ST_CLEAR: clr <= clr + MemAw'(1);
        ST_IDLE: if (in_valid) begin
          c <= core_id; op <= opcode; d <= dest_index;
          sa <= src_a_index; sb <= src_b_field;
          lane <= '0;
        end
        ST_EXEC: begin
          // a halted core reports its context unchanged
          if (active) begin
            pc_r[c] <= pc_new;
            fl_r[c] <= fl_new;
            if (op == OP_HALT) hlt[c] <= 1'b1;
          end
          core_out <= c;
          next_pc <= active ? pc_new : pc_cur;
          {flag_overflow, flag_carry, flag_negative, flag_zero} <= active ? fl_new : fl_r[c];
          branch_taken <= active && taken;
          halted <= !active || (op == OP_HALT);
          scalar_written <= (active && is_sw) ? wres : '0;
        end
        ST_DIV: if (drsp.done) scalar_written <= drsp.quotient;
        ST_VLANE: lane <= lane + LaneW'(1);
        default: ;
      endcase
    end
  end
endmodule

@@ design/sveu_checker.sv @@
// port-level checker for the execute unit
`include "scalar_vector_execute_unit_defines.svh"
module sveu_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [1:0] core_out,
  input logic halted,
  input logic branch_taken,
  input logic [31:0] scalar_written
);
  `SVEU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")
  `SVEU_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(core_out), "result changed")
  `SVEU_ASSERT_IMP(a_busy, out_valid && out_stall, in_stall, "request taken while full")
  `SVEU_ASSERT_IMP(a_halt_quiet, out_valid && halted && branch_taken, 1'b0, "halted branch")
endmodule

bind scalar_vector_execute_unit sveu_checker u_chk (.*);

@@ bench/tb_scalar_vector_execute_unit.sv @@
// testbench for the scalar and vector execute unit
module tb_scalar_vector_execute_unit;
  import sveu_pkg::*;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 60;

  typedef struct {
    logic [1:0] core;
    logic [7:0] op;
    logic [7:0] dst;
    logic [7:0] srca;
    logic [7:0] srcb;
  } instr_t;

  typedef struct {
    logic [1:0]  core;
    logic [31:0] pc;
    logic        z, n, c, v, taken, halt;
    logic [31:0] wval;
  } exec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] core_id = '0;
  logic [7:0] opcode = '0, dest_index = '0, src_a_index = '0, src_b_field = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] core_out;
  logic [31:0] next_pc;
  logic flag_zero, flag_negative, flag_carry, flag_overflow, branch_taken, halted;
  logic signed [31:0] scalar_written;

  scalar_vector_execute_unit dut (.*);

  // shadow copy of every core's context
  logic [31:0] sreg [Cores][256];
  logic [31:0] vreg [Cores][32][Lanes];
  logic [31:0] core_pc [Cores];
  logic [3:0]  core_flags [Cores];   // {v, c, n, z}
  logic        core_halt [Cores];

  instr_t pending_instrs[$];
  exec_result_t expected_results[$];
  int n_requests = 0;
  int n_errors = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [31:0] signed_quot(logic [31:0] a, logic [31:0] b);
    longint q;
    q = longint'($signed(a)) / longint'($signed(b));
    return q[31:0];
  endfunction

  function automatic logic flags_meet(logic [3:0] f, logic [3:0] code);
    logic z, n, c, v;
    z = f[0]; n = f[1]; c = f[2]; v = f[3];
    case (code)
      4'h0: return z;
      4'h1: return !z;
      4'h2: return c;
      4'h3: return !c;
      4'h4: return n;
      4'h5: return !n;
      4'h6: return v;
      4'h7: return !v;
      4'h8: return c && !z;
      4'h9: return !c || z;
      4'hA: return n == v;
      4'hB: return n != v;
      4'hC: return !z && (n == v);
      4'hD: return z || (n != v);
      COND_ALWAYS: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // execute one instruction on the shadow context
  function automatic exec_result_t execute(instr_t it);
    exec_result_t r;
    logic [31:0] pc, a, b, s, x, y, res;
    logic [31:0] offs;
    logic wrote;
    logic [4:0] vd, va, vb;
    int c;
    c = it.core;
    wrote = 1'b0;
    res = '0;
    r.taken = 1'b0;
    vd = it.dst[4:0]; va = it.srca[4:0]; vb = it.srcb[4:0];
    if (!core_halt[c]) begin
      pc = core_pc[c];
      core_pc[c] = pc + 32'd4;
      a = sreg[c][it.srca];
      if (it.op == OP_HALT) begin
        core_halt[c] = 1'b1;
      end else if (it.op >= OP_BR_LO && it.op <= OP_BR_HI) begin
        if (flags_meet(core_flags[c], it.op[3:0])) begin
          offs = {{24{it.srcb[7]}}, it.srcb};
          core_pc[c] = pc + (offs << 2);
          r.taken = 1'b1;
        end
      end else begin
        case (it.op)
          OP_ADD, OP_ADDI: begin
            b = (it.op == OP_ADD) ? sreg[c][it.srcb] : {24'd0, it.srcb};
            res = a + b;
            core_flags[c] = {(a[31] == b[31]) && (res[31] != a[31]), res < a,
                             res[31], res == 0};
            wrote = 1'b1;
          end
          OP_SUB, OP_SUBI: begin
            b = (it.op == OP_SUB) ? sreg[c][it.srcb] : {24'd0, it.srcb};
            res = a - b;
            core_flags[c] = {(a[31] != b[31]) && (res[31] == b[31]), a >= b,
                             res[31], res == 0};
            wrote = 1'b1;
          end
          OP_MUL, OP_MULI: begin
            b = (it.op == OP_MUL) ? sreg[c][it.srcb] : {24'd0, it.srcb};
            res = a * b;
            wrote = 1'b1;
          end
          OP_DIV: begin
            b = sreg[c][it.srcb];
            if (b != 0) begin
              res = signed_quot(a, b);
              wrote = 1'b1;
            end
          end
          OP_DIVI: begin
            if (it.srca != 0 && it.srcb != 0) begin
              res = signed_quot(a, {24'd0, it.srcb});
              wrote = 1'b1;
            end
          end
          OP_MOV: begin
            res = sreg[c][it.srcb];
            wrote = 1'b1;
          end
          OP_LDI: begin
            res = {24'd0, it.srcb};
            wrote = 1'b1;
          end
          OP_VADD, OP_VSUB, OP_VMUL: begin
            for (int i = 0; i < Lanes; i++) begin
              x = vreg[c][va][i];
              y = vreg[c][vb][i];
              vreg[c][vd][i] = (it.op == OP_VADD) ? x + y :
                               (it.op == OP_VSUB) ? x - y : x * y;
            end
          end
          OP_VADDS, OP_VSUBS, OP_VMULS: begin
            s = (it.srcb < 32 && sreg[c][it.srcb] != 0) ? sreg[c][it.srcb]
                                                         : {24'd0, it.srcb};
            for (int i = 0; i < Lanes; i++) begin
              x = vreg[c][va][i];
              vreg[c][vd][i] = (it.op == OP_VADDS) ? x + s :
                               (it.op == OP_VSUBS) ? x - s : x * s;
            end
          end
          default: ;
        endcase
        if (wrote) sreg[c][it.dst] = res;
      end
    end
    r.core = it.core;
    r.pc = core_pc[c];
    {r.v, r.c, r.n, r.z} = core_flags[c];
    r.halt = core_halt[c];
    r.wval = wrote ? res : 32'd0;
    return r;
  endfunction

  function automatic void add_instr(int c, logic [7:0] op, int d, int a, int b);
    instr_t it;
    it.core = 2'(c); it.op = op; it.dst = 8'(d); it.srca = 8'(a); it.srcb = 8'(b);
    pending_instrs.push_back(it);
  endfunction

  // scalar indices cluster on a few registers so values build up
  function automatic int pick_reg();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
  endfunction

  function automatic int pick_vreg();
    return $urandom_range(0, 7) | ($urandom_range(0, 7) << 5);
  endfunction

  function automatic void add_random_instr();
    int c, k;
    logic [7:0] op;
    logic [7:0] arith [8];
    logic [7:0] vec [6];
    arith = '{OP_ADD, OP_SUB, OP_MUL, OP_MOV, OP_ADDI, OP_SUBI, OP_MULI, OP_ADD};
    vec = '{OP_VADD, OP_VSUB, OP_VMUL, OP_VADDS, OP_VSUBS, OP_VMULS};
    c = $urandom_range(0, Cores - 1);
    k = $urandom_range(0, 99);
    if (k < 35) begin
      add_instr(c, arith[$urandom_range(0, 7)], pick_reg(), pick_reg(),
                $urandom_range(0, 1) ? pick_reg() : $urandom_range(0, 255));
    end else if (k < 50) begin
      add_instr(c, OP_LDI, pick_reg(), $urandom_range(0, 255), $urandom_range(0, 255));
    end else if (k < 62) begin
      add_instr(c, 8'(OP_BR_LO + $urandom_range(0, 14)), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255));
    end else if (k < 80) begin
      add_instr(c, vec[$urandom_range(0, 5)], pick_vreg(), pick_vreg(),
                $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 255));
    end else if (k < 88) begin
      add_instr(c, $urandom_range(0, 1) ? OP_DIV : OP_DIVI, pick_reg(),
                $urandom_range(0, 7) == 0 ? 0 : pick_reg(),
                $urandom_range(0, 7) == 0 ? 0 : $urandom_range(0, 255));
    end else begin
      // any opcode but halt
      op = 8'($urandom_range(1, 255));
      add_instr(c, op, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255));
    end
  endfunction

  // driver: offers the next request, predicts on acceptance
  always @(posedge clk) begin
    instr_t it;
    int idle_pct;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        it.core = core_id; it.op = opcode; it.dst = dest_index;
        it.srca = src_a_index; it.srcb = src_b_field;
        expected_results.push_back(execute(it));
        n_requests++;
      end
      idle_pct = (n_requests < 383) ? 32 : (n_requests < 766) ? 50 : 0;
      if (!in_valid || !in_stall) begin
        if (pending_instrs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          it = pending_instrs.pop_front();
          core_id <= it.core; opcode <= it.op; dest_index <= it.dst;
          src_a_index <= it.srca; src_b_field <= it.srcb;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results and drives the output stall
  always @(posedge clk) begin
    exec_result_t e;
    int stall_pct;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result core %0d pc %h", core_out, next_pc);
        end else begin
          e = expected_results.pop_front();
          if (core_out !== e.core || next_pc !== e.pc || flag_zero !== e.z ||
              flag_negative !== e.n || flag_carry !== e.c || flag_overflow !== e.v ||
              branch_taken !== e.taken || halted !== e.halt ||
              scalar_written !== $signed(e.wval)) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: exp core %0d pc %h zncv %b%b%b%b br %b h %b w %h | %s",
                       e.core, e.pc, e.z, e.n, e.c, e.v, e.taken, e.halt, e.wval,
                       $sformatf("got core %0d pc %h zncv %b%b%b%b br %b h %b w %h",
                                 core_out, next_pc, flag_zero, flag_negative, flag_carry,
                                 flag_overflow, branch_taken, halted, scalar_written));
          end
        end
      end
      // one long hold-off so the input backs up
      if (!hold_done && n_requests >= 500) begin
        hold_done <= 1'b1;
        hold_left <= 250;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        stall_pct = (n_requests < 383) ? 50 : (n_requests < 766) ? 32 : 0;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int c = 0; c < Cores; c++) begin
      core_pc[c] = '0; core_flags[c] = '0; core_halt[c] = 1'b0;
      for (int i = 0; i < 256; i++) sreg[c][i] = '0;
      for (int i = 0; i < 32; i++)
        for (int l = 0; l < Lanes; l++) vreg[c][i][l] = '0;
    end

    // build 0x80000000 in r1 and -1 in r2, then the wrapping divide
    add_instr(0, OP_LDI, 1, 0, 128);
    add_instr(0, OP_MULI, 1, 1, 128);
    add_instr(0, OP_MULI, 1, 1, 128);
    add_instr(0, OP_MULI, 1, 1, 128);
    add_instr(0, OP_MULI, 1, 1, 8);
    add_instr(0, OP_SUBI, 2, 0, 1);
    add_instr(0, OP_DIV, 3, 1, 2);
    // divide by zero register, divide by constant forms
    add_instr(0, OP_DIV, 4, 1, 9);
    add_instr(0, OP_DIVI, 5, 1, 255);
    add_instr(0, OP_DIVI, 5, 0, 7);
    add_instr(0, OP_DIVI, 5, 1, 0);
    // add with carry and overflow, subtract borrow, max immediate
    add_instr(0, OP_ADD, 6, 1, 1);
    add_instr(0, OP_SUB, 7, 0, 2);
    add_instr(0, OP_ADDI, 255, 2, 255);
    add_instr(0, OP_MOV, 8, 0, 1);
    add_instr(0, OP_MUL, 9, 2, 2);
    // vector ops with indices above 31, scalar operand and immediate
    add_instr(1, OP_VADDS, 33, 0, 255);
    add_instr(1, OP_LDI, 3, 0, 7);
    add_instr(1, OP_VMULS, 2, 1, 3);
    add_instr(1, OP_VSUBS, 255, 224, 200);
    add_instr(1, OP_VADD, 4, 1, 2);
    add_instr(1, OP_VSUB, 5, 4, 31);
    add_instr(1, OP_VMUL, 6, 4, 2);
    // every branch condition, negative and positive offsets
    for (int k = 0; k <= 14; k++)
      add_instr(2, 8'(OP_BR_LO + k), 0, 0, (k & 1) ? 8'h80 : 8'h7F);
    add_instr(2, 8'h1F, 0, 0, 0);
    add_instr(2, 8'hFF, 255, 255, 255);

    for (int k = 0; k < 1110; k++) add_random_instr();

    // halt every core, then show the halted ones ignore instructions
    for (int c = 0; c < Cores; c++) begin
      add_instr(c, OP_HALT, 0, 0, 0);
      add_instr(c, OP_LDI, 1, 0, 5);
      add_instr(c, OP_BR_LO + COND_ALWAYS, 0, 0, 4);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_instrs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
